// File: hw/rtl/powerline_frame_receiver_core_defines.svh
// Assertion macros used by the receiver top level.
`ifndef POWERLINE_FRAME_RECEIVER_CORE_DEFINES_SVH
`define POWERLINE_FRAME_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PRX_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PRX_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/prx_pkg.sv
// Types and constants of the powerline frame receiver.
package prx_pkg;

	localparam int LineW  = 9;
	localparam int CmdW   = 5;
	localparam int HouseW = 4;
	localparam int PosW   = 5;
	localparam int CfgIdxW = 2;

	localparam logic [PosW-1:0] LastLinePos   = 5'd8;
	localparam logic [PosW-1:0] LastRepeatPos = 5'd17;
	localparam logic [PosW-1:0] LineBits      = 5'd9;
	localparam logic [3:0]      StartCode     = 4'hE;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] CfgUnitAddress = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgOnCode      = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgOffCode     = 2'd2;

	typedef struct packed {
		logic [LineW-1:0] unit_address;
		logic [CmdW-1:0]  on_code;
		logic [CmdW-1:0]  off_code;
	} prx_cfg_t;

	// Control state, cleared by reset
	typedef struct packed {
		logic [3:0]       start_shift;
		logic             start_found;
		logic             half_phase;
		logic             first_half;
		logic [PosW-1:0]  bit_position;
		logic             line_accepted;
		logic [LineW-1:0] accepted_line;
		logic             listen_flag;
		logic             ack_flag;
		logic             handle_flag;
		logic             lamp_flag;
	} prx_ctrl_t;

	typedef struct packed {
		logic             half_bit;
		logic             line_valid;
		logic [LineW-1:0] line_value;
		logic             listening;
		logic             acknowledge;
		logic             handle_pending;
		logic             lamp_on;
	} prx_res_t;

endpackage

// File: hw/rtl/prx_step.sv
// Next-state and result logic for one zero-crossing item.
module prx_step (
	input  prx_pkg::prx_ctrl_t           cur,
	input  logic [prx_pkg::LineW-1:0]    line_store,
	input  logic [prx_pkg::LineW-1:0]    repeat_store,
	input  prx_pkg::prx_cfg_t            cfg,
	input  logic                         first_sample,
	input  logic                         second_sample,
	output prx_pkg::prx_ctrl_t           nxt,
	output logic [prx_pkg::LineW-1:0]    line_store_nxt,
	output logic [prx_pkg::LineW-1:0]    repeat_store_nxt,
	output prx_pkg::prx_res_t            res
);

	logic                       hb;
	logic                       done;
	logic                       dec_bit;
	logic                       line_done;
	logic                       valid;
	logic                       house_ok;
	logic [prx_pkg::PosW-1:0]   rep_pos;
	logic [prx_pkg::CmdW-1:0]   cmd;

	always_comb begin
		nxt              = cur;
		line_store_nxt   = line_store;
		repeat_store_nxt = repeat_store;
		done             = 1'b0;
		line_done        = 1'b0;
		valid            = 1'b0;
		hb               = first_sample & second_sample;
		dec_bit          = cur.first_half & ~hb;
		rep_pos          = cur.bit_position - prx_pkg::LineBits;

		// hunt for start code; the step that finds it does nothing else
		if (!cur.start_found) begin
			nxt.start_shift = {cur.start_shift[2:0], hb};
			if (nxt.start_shift == prx_pkg::StartCode) begin
				nxt.start_found = 1'b1;
				done            = 1'b1;
			end
		end

		// pair half-bits: 10 decodes to one, anything else to zero
		if (!done && nxt.start_found) begin
			if (!cur.half_phase) begin
				nxt.first_half = hb;
				nxt.half_phase = 1'b1;
			end else begin
				nxt.half_phase = 1'b0;
				nxt.first_half = 1'b0;
				if (cur.bit_position <= prx_pkg::LastLinePos) begin
					for (int i = 0; i < prx_pkg::LineW; i++) begin
						if (cur.bit_position[3:0] == 4'(i)) line_store_nxt[i] = dec_bit;
					end
					if (cur.bit_position == prx_pkg::LastLinePos) nxt.start_found = 1'b0;
					nxt.bit_position = cur.bit_position + 5'd1;
				end else if (cur.bit_position <= prx_pkg::LastRepeatPos) begin
					for (int i = 0; i < prx_pkg::LineW; i++) begin
						if (rep_pos[3:0] == 4'(i)) repeat_store_nxt[i] = dec_bit;
					end
					if (cur.bit_position == prx_pkg::LastRepeatPos) begin
						line_done        = 1'b1;
						nxt.start_found  = 1'b0;
						nxt.bit_position = '0;
					end else begin
						nxt.bit_position = cur.bit_position + 5'd1;
					end
				end
			end
		end

		// repeat check
		if (!done && line_done) begin
			if (line_store_nxt == repeat_store_nxt) begin
				nxt.accepted_line = line_store_nxt;
				nxt.line_accepted = 1'b1;
				valid             = 1'b1;
			end else begin
				nxt.line_accepted = 1'b0;
			end
		end

		// address line: own address arms listening and ends the step
		if (!done && nxt.line_accepted && !nxt.accepted_line[prx_pkg::LineW-1]) begin
			nxt.line_accepted = 1'b0;
			if (nxt.accepted_line == cfg.unit_address) begin
				nxt.listen_flag = 1'b1;
				done            = 1'b1;
			end else begin
				nxt.listen_flag = 1'b0;
			end
		end

		// command line; ON wins over OFF when codes are equal
		cmd      = nxt.accepted_line[prx_pkg::LineW-1:prx_pkg::HouseW];
		house_ok = nxt.accepted_line[prx_pkg::HouseW-1:0]
			== cfg.unit_address[prx_pkg::HouseW-1:0];
		if (!done && nxt.listen_flag && nxt.accepted_line[prx_pkg::LineW-1]) begin
			nxt.listen_flag = 1'b0;
			nxt.handle_flag = 1'b1;
			if (house_ok && cmd == cfg.on_code) begin
				nxt.lamp_flag = 1'b1;
				nxt.ack_flag  = 1'b1;
			end else if (house_ok && cmd == cfg.off_code) begin
				nxt.lamp_flag = 1'b0;
				nxt.ack_flag  = 1'b1;
			end else begin
				nxt.ack_flag  = 1'b0;
			end
		end

		res.half_bit       = hb;
		res.line_valid     = valid;
		res.line_value     = nxt.accepted_line;
		res.listening      = nxt.listen_flag;
		res.acknowledge    = nxt.ack_flag;
		res.handle_pending = nxt.handle_flag;
		res.lamp_on        = nxt.lamp_flag;
	end

endmodule

// File: hw/rtl/powerline_frame_receiver_core.sv
// Top level of the powerline frame receiver: input stage, state and result register.
//
// Channel  Handshake           Payload
// in       in_valid/in_stall   first_sample, second_sample
// out      out_valid/out_stall half_bit, line_valid, line_value, listening,
//                              acknowledge, handle_pending, lamp_on
// cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item per cycle unless out_stall holds a valid result; each item passes the
// input register, then the single-pass state update into the result register.
// Reset clears all control state; the line and repeat stores are not reset.
// A stalled result holds the result register; the input stage still takes
// an item while the result register frees in the same cycle.
`include "powerline_frame_receiver_core_defines.svh"

module powerline_frame_receiver_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                first_sample,
	input  logic                                second_sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                half_bit,
	output logic                                line_valid,
	output logic [prx_pkg::LineW-1:0]           line_value,
	output logic                                listening,
	output logic                                acknowledge,
	output logic                                handle_pending,
	output logic                                lamp_on,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [prx_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [prx_pkg::LineW-1:0]           cfg_data
);

	logic                        valid_s1;
	logic                        first_s1;
	logic                        second_s1;
	logic                        out_valid_q;
	logic                        out_free;
	logic                        adv;
	prx_pkg::prx_res_t           res_q;
	prx_pkg::prx_res_t           res_nxt;
	prx_pkg::prx_ctrl_t          ctrl_q;
	prx_pkg::prx_ctrl_t          ctrl_nxt;
	prx_pkg::prx_cfg_t           cfg_q;
	logic [prx_pkg::LineW-1:0]   line_store_q;
	logic [prx_pkg::LineW-1:0]   repeat_store_q;
	logic [prx_pkg::LineW-1:0]   line_store_nxt;
	logic [prx_pkg::LineW-1:0]   repeat_store_nxt;

	// flow control
	assign out_free  = !out_valid_q || !out_stall;
	assign adv       = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				prx_pkg::CfgUnitAddress: cfg_q.unit_address <= cfg_data;
				prx_pkg::CfgOnCode:      cfg_q.on_code <= cfg_data[prx_pkg::CmdW-1:0];
				prx_pkg::CfgOffCode:     cfg_q.off_code <= cfg_data[prx_pkg::CmdW-1:0];
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			first_s1  <= first_sample;
			second_s1 <= second_sample;
		end
	end

	prx_step u_step (
		.cur              (ctrl_q),
		.line_store       (line_store_q),
		.repeat_store     (repeat_store_q),
		.cfg              (cfg_q),
		.first_sample     (first_s1),
		.second_sample    (second_s1),
		.nxt              (ctrl_nxt),
		.line_store_nxt   (line_store_nxt),
		.repeat_store_nxt (repeat_store_nxt),
		.res              (res_nxt)
	);

	// control state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) ctrl_q <= ctrl_nxt;
			if (out_free) out_valid_q <= valid_s1;
		end
	end

	// line stores and result payload
	always_ff @(posedge clk) begin
		if (adv) begin
			line_store_q   <= line_store_nxt;
			repeat_store_q <= repeat_store_nxt;
			res_q          <= res_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign half_bit       = res_q.half_bit;
	assign line_valid     = res_q.line_valid;
	assign line_value     = res_q.line_value;
	assign listening      = res_q.listening;
	assign acknowledge    = res_q.acknowledge;
	assign handle_pending = res_q.handle_pending;
	assign lamp_on        = res_q.lamp_on;

	`PRX_ASSERT_NXT(a_state_holds, clk, arst_n, !adv, $stable(ctrl_q), "state changed without transfer")
	`PRX_ASSERT_NXT(a_res_matches, clk, arst_n, adv, res_q.line_value == ctrl_q.accepted_line, "result out of step with state")
	`PRX_ASSERT_NXT(a_handle_sticky, clk, arst_n, ctrl_q.handle_flag, ctrl_q.handle_flag, "handle flag dropped")
	`PRX_ASSERT_IMP(a_phase_in_frame, clk, arst_n, !ctrl_q.start_found, !ctrl_q.half_phase, "half phase set outside frame")

endmodule

// File: dv/powerline_frame_receiver_core_tb.sv
// Self-checking testbench for the powerline frame receiver core.
`timescale 1ns / 1ps

module powerline_frame_receiver_core_tb;

	localparam int unsigned RandomItems   = 200;
	localparam int unsigned StreamItems   = 160;
	localparam int unsigned PressureItems = 80;
	localparam int unsigned HoldOffCycles = 200;
	localparam int unsigned QuietLimit    = 3000;
	localparam int unsigned PipeSettle    = 6;
	// width used to compare and print any status field
	localparam int          FieldW        = prx_pkg::LineW;

	logic                              clk;
	logic                              arst_n         = 1'b0;
	logic                              in_valid       = 1'b0;
	logic                              in_stall;
	logic                              first_sample   = 1'b0;
	logic                              second_sample  = 1'b0;
	logic                              out_valid;
	logic                              out_stall      = 1'b0;
	logic                              half_bit;
	logic                              line_valid;
	logic [prx_pkg::LineW-1:0]         line_value;
	logic                              listening;
	logic                              acknowledge;
	logic                              handle_pending;
	logic                              lamp_on;
	logic                              cfg_valid      = 1'b0;
	logic                              cfg_ready;
	logic [prx_pkg::CfgIdxW-1:0]       cfg_index      = '0;
	logic [prx_pkg::LineW-1:0]         cfg_data       = '0;

	// Shared run control
	bit                  idle_en  = 1'b1;
	bit                  hold_req = 1'b0;
	int unsigned         samples_sent    = 0;
	int unsigned         results_checked = 0;
	int unsigned         lines_matched   = 0;
	int unsigned         settings_used   = 0;
	int unsigned         mismatches      = 0;

	// Expected status words, oldest first
	prx_pkg::prx_res_t   pending_status[$];

	// Receiver state as the testbench tracks it
	logic [3:0]                  rx_start_shift   = '0;
	logic                        rx_start_found   = 1'b0;
	logic                        rx_half_phase    = 1'b0;
	logic                        rx_first_half    = 1'b0;
	logic [prx_pkg::PosW-1:0]    rx_pos           = '0;
	logic [prx_pkg::LineW-1:0]   rx_line_store    = '0;
	logic [prx_pkg::LineW-1:0]   rx_repeat_store  = '0;
	logic                        rx_line_complete = 1'b0;
	logic                        rx_line_accepted = 1'b0;
	logic [prx_pkg::LineW-1:0]   rx_accepted_line = '0;
	logic                        rx_listen        = 1'b0;
	logic                        rx_ack           = 1'b0;
	logic                        rx_handle        = 1'b0;
	logic                        rx_lamp          = 1'b0;

	// Register copies
	logic [prx_pkg::LineW-1:0]   cfg_unit = '0;
	logic [prx_pkg::CmdW-1:0]    cfg_on   = '0;
	logic [prx_pkg::CmdW-1:0]    cfg_off  = '0;

	powerline_frame_receiver_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.first_sample   (first_sample),
		.second_sample  (second_sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.half_bit       (half_bit),
		.line_valid     (line_valid),
		.line_value     (line_value),
		.listening      (listening),
		.acknowledge    (acknowledge),
		.handle_pending (handle_pending),
		.lamp_on        (lamp_on),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Advance the tracked receiver by one sample pair and return its status word
	function automatic prx_pkg::prx_res_t decode_sample(input logic fs, input logic ss);
		prx_pkg::prx_res_t          res;
		logic                       hb;
		logic                       bit_in;
		logic                       matched;
		logic                       done;
		logic [prx_pkg::PosW-1:0]   rep_pos;
		logic [prx_pkg::CmdW-1:0]   cmd;
		hb      = fs & ss;
		matched = 1'b0;
		done    = 1'b0;
		// start code hunt; the completing step does nothing else
		if (!rx_start_found) begin
			rx_start_shift = {rx_start_shift[2:0], hb};
			if (rx_start_shift == prx_pkg::StartCode) begin
				rx_start_found = 1'b1;
				done = 1'b1;
			end
		end
		// half-bit pairing: 10 is a one, anything else a zero
		if (!done && rx_start_found) begin
			if (!rx_half_phase) begin
				rx_first_half = hb;
				rx_half_phase = 1'b1;
			end else begin
				bit_in = rx_first_half & ~hb;
				if (rx_pos <= prx_pkg::LastLinePos) begin
					rx_line_store[rx_pos[3:0]] = bit_in;
					if (rx_pos >= prx_pkg::LastLinePos)
						rx_start_found = 1'b0;
					rx_pos = rx_pos + 5'd1;
				end else if (rx_pos <= prx_pkg::LastRepeatPos) begin
					rep_pos = rx_pos - prx_pkg::LineBits;
					rx_repeat_store[rep_pos[3:0]] = bit_in;
					if (rx_pos >= prx_pkg::LastRepeatPos) begin
						rx_line_complete = 1'b1;
						rx_start_found   = 1'b0;
						rx_pos           = '0;
					end else begin
						rx_line_complete = 1'b0;
						rx_pos           = rx_pos + 5'd1;
					end
				end
				rx_half_phase = 1'b0;
				rx_first_half = 1'b0;
			end
		end
		// line against repeat
		if (!done && rx_line_complete) begin
			if (rx_line_store == rx_repeat_store) begin
				rx_accepted_line = rx_line_store;
				rx_line_accepted = 1'b1;
				matched = 1'b1;
			end else begin
				rx_line_accepted = 1'b0;
			end
			rx_line_complete = 1'b0;
		end
		// address line: arming listening skips the command check
		if (!done && rx_line_accepted && !rx_accepted_line[prx_pkg::LineW-1]) begin
			rx_line_accepted = 1'b0;
			if (rx_accepted_line == cfg_unit) begin
				rx_listen = 1'b1;
				done = 1'b1;
			end else begin
				rx_listen = 1'b0;
			end
		end
		// command line: house code, then ON before OFF
		if (!done && rx_listen && rx_accepted_line[prx_pkg::LineW-1]) begin
			cmd = rx_accepted_line[prx_pkg::LineW-1:prx_pkg::HouseW];
			if (rx_accepted_line[prx_pkg::HouseW-1:0] != cfg_unit[prx_pkg::HouseW-1:0]) begin
				rx_ack = 1'b0;
			end else if (cmd == cfg_on) begin
				rx_lamp = 1'b1;
				rx_ack  = 1'b1;
			end else if (cmd == cfg_off) begin
				rx_lamp = 1'b0;
				rx_ack  = 1'b1;
			end else begin
				rx_ack = 1'b0;
			end
			rx_listen = 1'b0;
			rx_handle = 1'b1;
		end
		res.half_bit       = hb;
		res.line_valid     = matched;
		res.line_value     = rx_accepted_line;
		res.listening      = rx_listen;
		res.acknowledge    = rx_ack;
		res.handle_pending = rx_handle;
		res.lamp_on        = rx_lamp;
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [FieldW-1:0] want,
			input logic [FieldW-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// One sample-pair transfer, with an optional gap before it
	task automatic send_item(input logic fs, input logic ss);
		int unsigned gap;
		gap = 0;
		if (idle_en && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		first_sample  <= fs;
		second_sample <= ss;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_status.push_back(decode_sample(fs, ss));
		samples_sent++;
	endtask

	// A half-bit of one is both samples high; a zero is any other pair
	task automatic send_half(input logic hb);
		int unsigned pick;
		pick = $urandom_range(0, 2);
		if (hb)
			send_item(1'b1, 1'b1);
		else
			send_item(pick == 2, pick == 1);
	endtask

	task automatic send_bit(input logic b);
		int unsigned pick;
		pick = $urandom_range(0, 3);
		if (b) begin
			send_half(1'b1);
			send_half(1'b0);
		end else begin
			// 01 mostly, 00 and 11 now and then
			send_half(pick == 3);
			send_half(pick != 2);
		end
	endtask

	task automatic send_start();
		for (int i = 3; i >= 0; i--)
			send_half(prx_pkg::StartCode[i]);
	endtask

	task automatic send_line(input logic [prx_pkg::LineW-1:0] line);
		for (int i = 0; i < prx_pkg::LineW; i++)
			send_bit(line[i]);
	endtask

	// Line and repeat, after bringing the receiver back to an idle hunt
	task automatic send_frame(input logic [prx_pkg::LineW-1:0] line,
			input logic [prx_pkg::LineW-1:0] rpt);
		while (rx_start_found || rx_pos != 0) begin
			if (rx_start_found)
				send_half(1'b0);
			else
				send_start();
		end
		send_start();
		send_line(line);
		send_start();
		send_line(rpt);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_status.size() != 0) @(posedge clk);
		repeat (PipeSettle) @(posedge clk);
	endtask

	task automatic write_reg(input logic [prx_pkg::CfgIdxW-1:0] idx,
			input logic [prx_pkg::LineW-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			prx_pkg::CfgUnitAddress: cfg_unit = data;
			prx_pkg::CfgOnCode:      cfg_on   = data[prx_pkg::CmdW-1:0];
			prx_pkg::CfgOffCode:     cfg_off  = data[prx_pkg::CmdW-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Registers change only once the pipeline is empty
	task automatic apply_settings(input logic [prx_pkg::LineW-1:0] unit,
			input logic [prx_pkg::CmdW-1:0] on, input logic [prx_pkg::CmdW-1:0] off);
		drain_results();
		write_reg(prx_pkg::CfgUnitAddress, unit);
		// upper data bits are junk the code registers must drop
		write_reg(prx_pkg::CfgOnCode, {4'($urandom), on});
		write_reg(prx_pkg::CfgOffCode, {4'($urandom), off});
		settings_used++;
	endtask

	// Mostly address plus command sequences, with noise and broken frames mixed in
	task automatic run_traffic_phase(input int unsigned n);
		int unsigned                  stop_at;
		int unsigned                  kind;
		int unsigned                  len;
		logic [prx_pkg::LineW-1:0]    line;
		logic [prx_pkg::CmdW-1:0]     cmd;
		logic [prx_pkg::HouseW-1:0]   house;
		stop_at = samples_sent + n;
		while (samples_sent < stop_at) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				if ($urandom_range(0, 9) == 0)
					line = {1'b0, 8'($urandom)};
				else
					line = cfg_unit;
				send_frame(line, line);
				house = ($urandom_range(0, 6) == 0) ? 4'($urandom)
					: cfg_unit[prx_pkg::HouseW-1:0];
				case ($urandom_range(0, 2))
					0: cmd = cfg_on;
					1: cmd = cfg_off;
					default: cmd = 5'($urandom);
				endcase
				cmd[prx_pkg::CmdW-1] = 1'b1;
				line = {cmd, house};
				send_frame(line, line);
			end else if (kind < 70) begin
				line = 9'($urandom);
				send_frame(line, line);
			end else if (kind < 82) begin
				line = 9'($urandom);
				send_frame(line, line ^ (9'd1 << $urandom_range(0, 8)));
			end else if (kind < 92) begin
				len = $urandom_range(1, 12);
				repeat (len) send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else begin
				send_start();
				len = $urandom_range(1, 8);
				repeat (len) send_bit(1'($urandom_range(0, 1)));
			end
		end
	endtask

	// Status straight after reset, every sample pair, a bare start code
	task automatic test_reset_and_samples();
		send_item(1'b0, 1'b0);
		send_item(1'b0, 1'b1);
		send_item(1'b1, 1'b0);
		send_item(1'b1, 1'b1);
		send_item(1'b1, 1'b1);
		send_item(1'b1, 1'b1);
		send_item(1'b0, 1'b1);
		send_item(1'b1, 1'b0);
	endtask

	// Own address arms listening, then ON, OFF, and a command with nobody listening
	task automatic test_address_and_switching();
		logic [prx_pkg::LineW-1:0] addr;
		logic [prx_pkg::CmdW-1:0]  on;
		logic [prx_pkg::CmdW-1:0]  off;
		addr = 9'h0A5;
		on   = 5'h12;
		off  = 5'h1C;
		apply_settings(addr, on, off);
		send_frame(addr, addr);
		send_frame({on, addr[prx_pkg::HouseW-1:0]}, {on, addr[prx_pkg::HouseW-1:0]});
		send_frame(addr, addr);
		send_frame({off, addr[prx_pkg::HouseW-1:0]}, {off, addr[prx_pkg::HouseW-1:0]});
		send_frame({on, addr[prx_pkg::HouseW-1:0]}, {on, addr[prx_pkg::HouseW-1:0]});
	endtask

	// Wrong house code, unknown command, foreign address clearing listening
	task automatic test_rejected_commands();
		logic [prx_pkg::LineW-1:0] other;
		logic [prx_pkg::LineW-1:0] bad_house;
		logic [prx_pkg::LineW-1:0] unknown;
		logic [prx_pkg::LineW-1:0] good;
		other     = 9'h05A;
		bad_house = {cfg_on, ~cfg_unit[prx_pkg::HouseW-1:0]};
		unknown   = {5'h1F, cfg_unit[prx_pkg::HouseW-1:0]};
		good      = {cfg_on, cfg_unit[prx_pkg::HouseW-1:0]};
		send_frame(cfg_unit, cfg_unit);
		send_frame(bad_house, bad_house);
		send_frame(cfg_unit, cfg_unit);
		send_frame(unknown, unknown);
		send_frame(cfg_unit, cfg_unit);
		send_frame(other, other);
		send_frame(good, good);
	endtask

	// A repeat that differs must not deliver, and must not drop listening
	task automatic test_repeat_mismatch();
		logic [prx_pkg::LineW-1:0] cmd_line;
		cmd_line = {cfg_on, cfg_unit[prx_pkg::HouseW-1:0]};
		send_frame(cfg_unit, cfg_unit ^ 9'h010);
		send_frame(cfg_unit, cfg_unit);
		send_frame(cmd_line, cmd_line ^ 9'h001);
		send_frame(cmd_line, cmd_line);
	endtask

	// Same code for ON and OFF: ON wins
	task automatic test_equal_codes();
		apply_settings(9'h0A5, 5'h17, 5'h17);
		send_frame(cfg_unit, cfg_unit);
		send_frame({5'h17, cfg_unit[prx_pkg::HouseW-1:0]},
			{5'h17, cfg_unit[prx_pkg::HouseW-1:0]});
	endtask

	task automatic test_random_traffic();
		logic [prx_pkg::CmdW-1:0] on;
		logic [prx_pkg::CmdW-1:0] off;
		on  = {1'b1, 4'($urandom)};
		off = {1'b1, 4'($urandom)};
		if (off == on)
			off[0] = ~off[0];
		apply_settings({1'b0, 8'($urandom)}, on, off);
		run_traffic_phase(RandomItems / 4);
		apply_settings(9'h000, 5'h1F, 5'h10);
		run_traffic_phase(RandomItems / 4);
		apply_settings(9'h1FF, 5'h00, 5'h00);
		run_traffic_phase(RandomItems / 4);
		apply_settings(9'h0FF, 5'h1F, 5'h1F);
		run_traffic_phase(RandomItems / 4);
	endtask

	// Long receiver hold-off while samples keep coming, so the input stalls
	task automatic test_result_backpressure();
		drain_results();
		hold_req = 1'b1;
		run_traffic_phase(PressureItems);
		drain_results();
	endtask

	// Sender pauses for all results mid start code and mid line
	task automatic test_sender_pause();
		logic [prx_pkg::LineW-1:0] cmd_line;
		cmd_line = {cfg_on, cfg_unit[prx_pkg::HouseW-1:0]};
		send_frame(cfg_unit, cfg_unit);
		send_half(1'b1);
		send_half(1'b1);
		drain_results();
		send_half(1'b1);
		send_half(1'b0);
		for (int i = 0; i < prx_pkg::LineW; i++) begin
			send_bit(cmd_line[i]);
			if (i == 4)
				drain_results();
		end
		send_start();
		drain_results();
		send_line(cmd_line);
	endtask

	// Back-to-back transfers on both sides
	task automatic test_streaming();
		idle_en = 1'b0;
		apply_settings(9'h0C3, 5'h19, 5'h1E);
		run_traffic_phase(StreamItems);
	endtask

	// Receiver side: random stall bursts, plus one long hold-off on request
	initial begin : result_stall
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HoldOffCycles) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (idle_en && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Compare every status transfer with the oldest expectation
	always @(posedge clk) begin
		prx_pkg::prx_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_status.size() == 0) begin
				$display("%0t: status transfer with nothing expected, line_value %0h",
					$time, line_value);
				mismatches++;
			end else begin
				want = pending_status.pop_front();
				check_field("half_bit", FieldW'(want.half_bit), FieldW'(half_bit));
				check_field("line_valid", FieldW'(want.line_valid), FieldW'(line_valid));
				check_field("line_value", want.line_value, line_value);
				check_field("listening", FieldW'(want.listening), FieldW'(listening));
				check_field("acknowledge", FieldW'(want.acknowledge), FieldW'(acknowledge));
				check_field("handle_pending", FieldW'(want.handle_pending),
					FieldW'(handle_pending));
				check_field("lamp_on", FieldW'(want.lamp_on), FieldW'(lamp_on));
				results_checked++;
				if (want.line_valid)
					lines_matched++;
			end
		end
	end

	// Watchdog: too long without any transfer ends the run
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transfer for %0d cycles, %0d status words outstanding",
			$time, QuietLimit, pending_status.size());
		$display("powerline_frame_receiver_core test failed");
		$finish;
	end

	initial begin : stimulus
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_and_samples();
		test_address_and_switching();
		test_rejected_commands();
		test_repeat_mismatch();
		test_equal_codes();
		test_random_traffic();
		test_result_backpressure();
		test_sender_pause();
		test_streaming();
		drain_results();
		$display("sent %0d sample pairs, checked %0d status words, %0d line/repeat matches",
			samples_sent, results_checked, lines_matched);
		$display("register settings applied: %0d, mismatches: %0d", settings_used, mismatches);
		if (mismatches == 0)
			$display("powerline_frame_receiver_core test passed");
		else
			$display("powerline_frame_receiver_core test failed");
		$finish;
	end

endmodule
